[design/altt_pkg.sv]
// Shared types, constants and commands of the loudness and tempo tracker.
package altt_pkg;

  localparam int HIST_DEPTH    = 16;
  localparam int PEAK_DEPTH    = 8;
  localparam int WEIGHT_DEPTH  = 8;
  localparam logic [15:0] CHANGE_THRESH = 16'd256;
  localparam logic [15:0] W_ONE = 16'hFFFF;

  localparam int HIST_CW = $clog2(HIST_DEPTH + 1);
  localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int PEAK_CW = $clog2(PEAK_DEPTH + 1);
  localparam int PEAK_AW = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
  localparam int WGT_CW  = $clog2(WEIGHT_DEPTH + 1);
  localparam int WGT_AW  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;

  typedef logic [HIST_CW-1:0]      hcnt_t;
  typedef logic [HIST_AW-1:0]      hptr_t;
  typedef logic [16+HIST_CW-1:0]   hsum_t;
  typedef logic [PEAK_CW-1:0]      pcnt_t;
  typedef logic [PEAK_AW-1:0]      pptr_t;
  typedef logic [16+PEAK_CW-1:0]   psum_t;
  typedef logic [WGT_CW-1:0]       wcnt_t;
  typedef logic [WGT_AW-1:0]       wptr_t;
  typedef logic [16+WGT_CW-1:0]    wsum_t;

  localparam logic [2:0] REG_SILENCE_LEVEL  = 3'd0;
  localparam logic [2:0] REG_BEAT_RISE      = 3'd1;
  localparam logic [2:0] REG_INTENSITY_LOW  = 3'd2;
  localparam logic [2:0] REG_INTENSITY_HIGH = 3'd3;
  localparam logic [2:0] REG_RATIO_LOW      = 3'd4;
  localparam logic [2:0] REG_RATIO_HIGH     = 3'd5;
  localparam logic [2:0] REG_TEMPO_LOW      = 3'd6;
  localparam logic [2:0] REG_TEMPO_HIGH     = 3'd7;

  localparam logic [1:0] WSEL_INTENSITY = 2'd0;
  localparam logic [1:0] WSEL_BEAT      = 2'd1;
  localparam logic [1:0] WSEL_TEMPO     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SILENT, OP_TEMPO, OP_LOUD, OP_ALL, OP_FIX,
    OP_RATIO, OP_MAP, OP_WPUSH, OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_TEMPO, DST_LOUD, DST_PEAK, DST_ALL, DST_RATIO, DST_MAP, DST_WT
  } dst_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic silent;
    logic out_free;
  } status_t;

endpackage

[design/altt_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
module altt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_next;

  always_comb begin
    trial    = {rem, quo[31]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= 5'd31;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[30:0], ge};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[design/altt_datapath.sv]
// Datapath: registers, history windows, weight windows, divider and output register.
module altt_datapath (
  input  logic               clk,
  input  logic               rst,
  input  altt_pkg::cmd_t     cmd,
  output altt_pkg::status_t  status,
  input  logic               in_valid,
  input  logic               tempo_valid,
  input  logic [11:0]        tempo,
  input  logic               loud_valid,
  input  logic [15:0]        loudness,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        mean_tempo,
  output logic [15:0]        mean_loudness,
  output logic [15:0]        mean_peak,
  output logic [15:0]        intensity_weight,
  output logic [15:0]        beat_weight,
  output logic [15:0]        tempo_weight,
  output logic               silent
);

  // configuration
  logic [15:0] silence_level, beat_rise, intensity_low, intensity_high;
  logic [15:0] ratio_low, ratio_high;
  logic [11:0] tempo_low, tempo_high;

  // latched frame
  logic        in_tv, in_lv;
  logic [11:0] in_t;
  logic [15:0] in_l;

  // history windows
  logic [11:0]     tempo_ring [altt_pkg::HIST_DEPTH];
  logic [15:0]     loud_ring  [altt_pkg::HIST_DEPTH];
  logic [15:0]     all_ring   [altt_pkg::HIST_DEPTH];
  logic [15:0]     peak_ring  [altt_pkg::PEAK_DEPTH];
  altt_pkg::hcnt_t t_count, l_count, a_count;
  altt_pkg::hptr_t t_head, l_head, a_head;
  altt_pkg::hsum_t t_sum, l_sum, a_sum;
  altt_pkg::pcnt_t p_count;
  altt_pkg::pptr_t p_head;
  altt_pkg::psum_t p_sum;

  // weight windows
  logic [15:0]     wt_ring [3][altt_pkg::WEIGHT_DEPTH];
  altt_pkg::wcnt_t w_count [3];
  altt_pkg::wptr_t w_head  [3];
  altt_pkg::wsum_t w_sum   [3];
  logic [15:0]     w_mean  [3];

  logic [11:0] m_tempo;
  logic [15:0] m_loud, m_peak;
  logic [15:0] ratio, wmap;
  logic        silent_flag;

  altt_pkg::dst_t dst;
  logic [1:0]     dst_sel;

  // divider
  logic        div_start, div_busy, div_done;
  logic [31:0] div_dividend, div_q;
  logic [15:0] div_divisor;
  altt_pkg::dst_t dst_start;

  altt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // window push terms
  logic t_full, l_full, a_full, p_full, w_full;
  altt_pkg::hsum_t t_sum_next, l_sum_next, a_sum_next;
  altt_pkg::hcnt_t t_count_next, l_count_next, a_count_next;
  altt_pkg::hptr_t t_head_next, l_head_next, a_head_next;
  altt_pkg::psum_t p_sum_next;
  altt_pkg::pcnt_t p_count_next;
  altt_pkg::pptr_t p_head_next;
  altt_pkg::wsum_t w_sum_next;
  altt_pkg::wcnt_t w_count_next;
  altt_pkg::wptr_t w_head_next;
  logic [1:0]      ws;
  logic            is_peak;

  always_comb begin
    ws = cmd.sel;

    t_full       = t_count == altt_pkg::hcnt_t'(altt_pkg::HIST_DEPTH);
    t_sum_next   = t_sum - (t_full ? altt_pkg::hsum_t'(tempo_ring[t_head]) : '0)
                   + altt_pkg::hsum_t'(in_t);
    t_count_next = t_full ? t_count : altt_pkg::hcnt_t'(t_count + 1'b1);
    t_head_next  = (t_head == altt_pkg::hptr_t'(altt_pkg::HIST_DEPTH - 1)) ? '0
                   : altt_pkg::hptr_t'(t_head + 1'b1);

    l_full       = l_count == altt_pkg::hcnt_t'(altt_pkg::HIST_DEPTH);
    l_sum_next   = l_sum - (l_full ? altt_pkg::hsum_t'(loud_ring[l_head]) : '0)
                   + altt_pkg::hsum_t'(in_l);
    l_count_next = l_full ? l_count : altt_pkg::hcnt_t'(l_count + 1'b1);
    l_head_next  = (l_head == altt_pkg::hptr_t'(altt_pkg::HIST_DEPTH - 1)) ? '0
                   : altt_pkg::hptr_t'(l_head + 1'b1);

    a_full       = a_count == altt_pkg::hcnt_t'(altt_pkg::HIST_DEPTH);
    a_sum_next   = a_sum - (a_full ? altt_pkg::hsum_t'(all_ring[a_head]) : '0)
                   + altt_pkg::hsum_t'(in_l);
    a_count_next = a_full ? a_count : altt_pkg::hcnt_t'(a_count + 1'b1);
    a_head_next  = (a_head == altt_pkg::hptr_t'(altt_pkg::HIST_DEPTH - 1)) ? '0
                   : altt_pkg::hptr_t'(a_head + 1'b1);

    p_full       = p_count == altt_pkg::pcnt_t'(altt_pkg::PEAK_DEPTH);
    p_sum_next   = p_sum - (p_full ? altt_pkg::psum_t'(peak_ring[p_head]) : '0)
                   + altt_pkg::psum_t'(in_l);
    p_count_next = p_full ? p_count : altt_pkg::pcnt_t'(p_count + 1'b1);
    p_head_next  = (p_head == altt_pkg::pptr_t'(altt_pkg::PEAK_DEPTH - 1)) ? '0
                   : altt_pkg::pptr_t'(p_head + 1'b1);

    w_full       = w_count[ws] == altt_pkg::wcnt_t'(altt_pkg::WEIGHT_DEPTH);
    w_sum_next   = w_sum[ws] - (w_full ? altt_pkg::wsum_t'(wt_ring[ws][w_head[ws]]) : '0)
                   + altt_pkg::wsum_t'(wmap);
    w_count_next = w_full ? w_count[ws] : altt_pkg::wcnt_t'(w_count[ws] + 1'b1);
    w_head_next  = (w_head[ws] == altt_pkg::wptr_t'(altt_pkg::WEIGHT_DEPTH - 1)) ? '0
                   : altt_pkg::wptr_t'(w_head[ws] + 1'b1);

    is_peak = (m_loud != 16'd0) && (in_l >= m_loud) && (16'(in_l - m_loud) >= beat_rise);
  end

  // weight mapping
  logic [15:0] mx, mlo, mhi;
  logic [31:0] mprod;
  logic        map_hi, map_lo, map_eq;

  always_comb begin
    case (cmd.sel)
      altt_pkg::WSEL_INTENSITY: begin
        mx = m_loud; mlo = intensity_low; mhi = intensity_high;
      end
      altt_pkg::WSEL_BEAT: begin
        mx = ratio; mlo = ratio_low; mhi = ratio_high;
      end
      default: begin
        mx = 16'(m_tempo); mlo = 16'(tempo_low); mhi = 16'(tempo_high);
      end
    endcase
    map_hi = mx > mhi;
    map_lo = mx < mlo;
    map_eq = mhi == mlo;
    mprod  = 32'(16'(mx - mlo)) * 32'(altt_pkg::W_ONE);
  end

  // divider launch
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    dst_start    = altt_pkg::DST_NONE;
    case (cmd.op)
      altt_pkg::OP_TEMPO: if (in_tv) begin
        div_start    = 1'b1;
        div_dividend = 32'(t_sum_next);
        div_divisor  = 16'(t_count_next);
        dst_start    = altt_pkg::DST_TEMPO;
      end
      altt_pkg::OP_LOUD: if (in_lv) begin
        div_start = 1'b1;
        if (is_peak) begin
          div_dividend = 32'(p_sum_next);
          div_divisor  = 16'(p_count_next);
          dst_start    = altt_pkg::DST_PEAK;
        end else begin
          div_dividend = 32'(l_sum_next);
          div_divisor  = 16'(l_count_next);
          dst_start    = altt_pkg::DST_LOUD;
        end
      end
      altt_pkg::OP_ALL: if (in_lv) begin
        div_start    = 1'b1;
        div_dividend = 32'(a_sum_next);
        div_divisor  = 16'(a_count_next);
        dst_start    = altt_pkg::DST_ALL;
      end
      altt_pkg::OP_RATIO: if (m_loud != 16'd0) begin
        div_start    = 1'b1;
        div_dividend = {8'd0, m_peak, 8'd0};
        div_divisor  = m_loud;
        dst_start    = altt_pkg::DST_RATIO;
      end
      altt_pkg::OP_MAP: if (!map_hi && !map_lo && !map_eq) begin
        div_start    = 1'b1;
        div_dividend = mprod;
        div_divisor  = 16'(mhi - mlo);
        dst_start    = altt_pkg::DST_MAP;
      end
      altt_pkg::OP_WPUSH: begin
        div_start    = 1'b1;
        div_dividend = 32'(w_sum_next);
        div_divisor  = 16'(w_count_next);
        dst_start    = altt_pkg::DST_WT;
      end
      default: ;
    endcase
  end

  logic [15:0] q16, all_diff;
  logic        now_silent;

  always_comb begin
    q16        = div_q[15:0];
    all_diff   = (q16 >= m_peak) ? 16'(q16 - m_peak) : 16'(m_peak - q16);
    now_silent = m_loud < silence_level;
    status.busy     = div_busy | div_done;
    status.silent   = silent_flag;
    status.out_free = !out_valid || out_ready;
  end

  // ring payload, latched frame, ratio, map result and output register, no reset
  always_ff @(posedge clk) begin
    if (cmd.op == altt_pkg::OP_LOAD && in_valid) begin
      in_tv <= tempo_valid;
      in_t  <= tempo;
      in_lv <= loud_valid;
      in_l  <= loudness;
    end
    if (cmd.op == altt_pkg::OP_TEMPO && in_tv && !silent_flag) begin
      tempo_ring[t_head] <= in_t;
    end
    if (cmd.op == altt_pkg::OP_LOUD && in_lv) begin
      if (is_peak) begin
        peak_ring[p_head] <= in_l;
      end else begin
        loud_ring[l_head] <= in_l;
      end
    end
    if (cmd.op == altt_pkg::OP_ALL && in_lv) begin
      all_ring[a_head] <= in_l;
    end
    if (cmd.op == altt_pkg::OP_WPUSH) begin
      wt_ring[ws][w_head[ws]] <= wmap;
    end
    if (cmd.op == altt_pkg::OP_RATIO && m_loud == 16'd0) begin
      ratio <= altt_pkg::W_ONE;
    end
    if (cmd.op == altt_pkg::OP_MAP && (map_hi || map_lo || map_eq)) begin
      wmap <= map_hi ? altt_pkg::W_ONE : 16'd0;
    end
    if (div_done && dst == altt_pkg::DST_RATIO) begin
      ratio <= (div_q > 32'(altt_pkg::W_ONE)) ? altt_pkg::W_ONE : q16;
    end
    if (div_done && dst == altt_pkg::DST_MAP) begin
      wmap <= q16;
    end
    if (cmd.op == altt_pkg::OP_FINISH) begin
      mean_tempo       <= m_tempo;
      mean_loudness    <= m_loud;
      mean_peak        <= m_peak;
      intensity_weight <= w_mean[altt_pkg::WSEL_INTENSITY];
      beat_weight      <= w_mean[altt_pkg::WSEL_BEAT];
      tempo_weight     <= w_mean[altt_pkg::WSEL_TEMPO];
      silent           <= now_silent;
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_level  <= 16'd256;
      beat_rise      <= 16'd512;
      intensity_low  <= 16'd0;
      intensity_high <= 16'd65535;
      ratio_low      <= 16'd256;
      ratio_high     <= 16'd1024;
      tempo_low      <= 12'd600;
      tempo_high     <= 12'd1800;
      t_count <= '0; t_head <= '0; t_sum <= '0;
      l_count <= '0; l_head <= '0; l_sum <= '0;
      a_count <= '0; a_head <= '0; a_sum <= '0;
      p_count <= '0; p_head <= '0; p_sum <= '0;
      for (int i = 0; i < 3; i++) begin
        w_count[i] <= '0;
        w_head[i]  <= '0;
        w_sum[i]   <= '0;
        w_mean[i]  <= '0;
      end
      m_tempo     <= '0;
      m_loud      <= '0;
      m_peak      <= '0;
      silent_flag <= 1'b0;
      dst         <= altt_pkg::DST_NONE;
      dst_sel     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          altt_pkg::REG_SILENCE_LEVEL:  silence_level  <= cfg_data;
          altt_pkg::REG_BEAT_RISE:      beat_rise      <= cfg_data;
          altt_pkg::REG_INTENSITY_LOW:  intensity_low  <= cfg_data;
          altt_pkg::REG_INTENSITY_HIGH: intensity_high <= cfg_data;
          altt_pkg::REG_RATIO_LOW:      ratio_low      <= cfg_data;
          altt_pkg::REG_RATIO_HIGH:     ratio_high     <= cfg_data;
          altt_pkg::REG_TEMPO_LOW:      tempo_low      <= cfg_data[11:0];
          altt_pkg::REG_TEMPO_HIGH:     tempo_high     <= cfg_data[11:0];
          default: ;
        endcase
      end

      if (div_start) begin
        dst     <= dst_start;
        dst_sel <= ws;
      end

      case (cmd.op)
        altt_pkg::OP_SILENT: begin
          if (in_tv) m_tempo <= in_t;
          if (in_lv) begin
            m_loud <= in_l;
            m_peak <= in_l;
          end
        end
        altt_pkg::OP_TEMPO: if (in_tv) begin
          t_count <= t_count_next; t_head <= t_head_next; t_sum <= t_sum_next;
        end
        altt_pkg::OP_LOUD: if (in_lv) begin
          if (is_peak) begin
            p_count <= p_count_next; p_head <= p_head_next; p_sum <= p_sum_next;
          end else begin
            l_count <= l_count_next; l_head <= l_head_next; l_sum <= l_sum_next;
          end
        end
        altt_pkg::OP_ALL: if (in_lv) begin
          a_count <= a_count_next; a_head <= a_head_next; a_sum <= a_sum_next;
        end
        altt_pkg::OP_FIX: if (m_peak < m_loud) m_peak <= m_loud;
        altt_pkg::OP_WPUSH: begin
          w_count[ws] <= w_count_next;
          w_head[ws]  <= w_head_next;
          w_sum[ws]   <= w_sum_next;
        end
        altt_pkg::OP_FINISH: begin
          if (now_silent && !silent_flag) begin
            t_count <= '0; t_head <= '0; t_sum <= '0;
            l_count <= '0; l_head <= '0; l_sum <= '0;
            a_count <= '0; a_head <= '0; a_sum <= '0;
            p_count <= '0; p_head <= '0; p_sum <= '0;
          end
          silent_flag <= now_silent;
        end
        default: ;
      endcase

      if (div_done) begin
        case (dst)
          altt_pkg::DST_TEMPO: m_tempo <= div_q[11:0];
          altt_pkg::DST_LOUD:  m_loud  <= q16;
          altt_pkg::DST_PEAK:  m_peak  <= q16;
          altt_pkg::DST_ALL: begin
            if (all_diff >= altt_pkg::CHANGE_THRESH) m_loud <= q16;
          end
          altt_pkg::DST_WT:    w_mean[dst_sel] <= q16;
          default: ;
        endcase
      end

      if (cmd.op == altt_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/altt_ctrl.sv]
// Controller: sequences the per-frame operations of the datapath.
module altt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  altt_pkg::status_t  status,
  output altt_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SIL, S_TEMPO, S_TWAIT, S_LOUD, S_LWAIT, S_ALL, S_AWAIT, S_FIX,
    S_RATIO, S_RWAIT, S_MAP, S_MWAIT, S_WPUSH, S_WWAIT, S_FIN
  } state_t;

  state_t     state;
  logic [1:0] wsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wsel  <= altt_pkg::WSEL_INTENSITY;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= status.silent ? S_SIL : S_TEMPO;
        S_SIL:   state <= S_RATIO;
        S_TEMPO: state <= S_TWAIT;
        S_TWAIT: if (!status.busy) state <= S_LOUD;
        S_LOUD:  state <= S_LWAIT;
        S_LWAIT: if (!status.busy) state <= S_ALL;
        S_ALL:   state <= S_AWAIT;
        S_AWAIT: if (!status.busy) state <= S_FIX;
        S_FIX:   state <= S_RATIO;
        S_RATIO: state <= S_RWAIT;
        S_RWAIT: if (!status.busy) state <= S_MAP;
        S_MAP:   state <= S_MWAIT;
        S_MWAIT: if (!status.busy) state <= S_WPUSH;
        S_WPUSH: state <= S_WWAIT;
        S_WWAIT: if (!status.busy) begin
          if (wsel == altt_pkg::WSEL_TEMPO) begin
            wsel  <= altt_pkg::WSEL_INTENSITY;
            state <= S_FIN;
          end else begin
            wsel  <= wsel + 2'd1;
            state <= S_MAP;
          end
        end
        S_FIN:   if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready = state == S_IDLE;
    cmd.sel  = wsel;
    unique case (state)
      S_IDLE:  cmd.op = altt_pkg::OP_LOAD;
      S_SIL:   cmd.op = altt_pkg::OP_SILENT;
      S_TEMPO: cmd.op = altt_pkg::OP_TEMPO;
      S_LOUD:  cmd.op = altt_pkg::OP_LOUD;
      S_ALL:   cmd.op = altt_pkg::OP_ALL;
      S_FIX:   cmd.op = altt_pkg::OP_FIX;
      S_RATIO: cmd.op = altt_pkg::OP_RATIO;
      S_MAP:   cmd.op = altt_pkg::OP_MAP;
      S_WPUSH: cmd.op = altt_pkg::OP_WPUSH;
      S_FIN:   cmd.op = status.out_free ? altt_pkg::OP_FINISH : altt_pkg::OP_NONE;
      default: cmd.op = altt_pkg::OP_NONE;
    endcase
  end

endmodule

[design/audio_loudness_tempo_tracker.sv]
// Top level of the audio loudness and tempo tracker.
//
// Input channel (in_valid/in_ready): one feature frame per transfer, tempo
// and loudness each with a valid bit. Output channel (out_valid/out_ready):
// one result per frame, held in an output register until transferred.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write only while no frame is in flight.
// Each frame runs through up to ten divisions on one shared restoring
// divider. The next frame is taken the cycle after the result is loaded
// into the output register, so frames are handled one at a time.
// If the receiver stalls with a result still waiting, the next frame is
// computed and then held until the output register frees up.
// Reset (rst, synchronous) empties all windows, zeroes the means, clears the
// silence flag and restores the register defaults; no clearing pass.
module audio_loudness_tempo_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        tempo_valid,
  input  logic [11:0] tempo,
  input  logic        loud_valid,
  input  logic [15:0] loudness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] mean_tempo,
  output logic [15:0] mean_loudness,
  output logic [15:0] mean_peak,
  output logic [15:0] intensity_weight,
  output logic [15:0] beat_weight,
  output logic [15:0] tempo_weight,
  output logic        silent,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  altt_pkg::cmd_t    cmd;
  altt_pkg::status_t status;

  assign cfg_ready = 1'b1;

  altt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  altt_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_valid         (in_valid),
    .tempo_valid      (tempo_valid),
    .tempo            (tempo),
    .loud_valid       (loud_valid),
    .loudness         (loudness),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mean_tempo       (mean_tempo),
    .mean_loudness    (mean_loudness),
    .mean_peak        (mean_peak),
    .intensity_weight (intensity_weight),
    .beat_weight      (beat_weight),
    .tempo_weight     (tempo_weight),
    .silent           (silent)
  );

endmodule
